// File: rtl/core/dq_voltage_pi_with_vector_limit_top_defines.svh
// ----------------------------------------------------------------------------
// dq_voltage_pi_with_vector_limit_top_defines
// Assertion macros of the dq voltage regulator, used by its sequencer.
// ----------------------------------------------------------------------------
`ifndef DQ_VOLTAGE_PI_WITH_VECTOR_LIMIT_TOP_DEFINES_SVH
`define DQ_VOLTAGE_PI_WITH_VECTOR_LIMIT_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define DQVL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define DQVL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/dqvl_pkg.sv
// ----------------------------------------------------------------------------
// dqvl_pkg
// Types, state codes, constants and fixed-point helpers of the dq regulator.
// ----------------------------------------------------------------------------
package dqvl_pkg;

	// Fixed-point format of all voltage values.
	localparam int ValueWidth = 32;
	localparam int FracBits = 16;

	// 1/sqrt(3) in Q2.30.
	localparam logic signed [33:0] InvSqrt3Q30 = 34'sd619925131;

	// Rounding shifts used by the datapath.
	localparam logic [4:0] SHIFT_PARK = 5'd15;
	localparam logic [4:0] SHIFT_FRAC = 5'd16;
	localparam logic [4:0] SHIFT_Q30 = 5'd30;

	// Iterative units run 32 steps.
	localparam logic [4:0] ITER_LAST = 5'd31;

	// Configuration register indexes and address width.
	localparam int CfgAddrWidth = 5;
	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_KP = 3'd1;
	localparam logic [2:0] REG_KI = 3'd2;
	localparam logic [2:0] REG_LIMIT = 3'd3;
	localparam logic [2:0] REG_UTIL = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [30:0] LIMIT_RESET = 31'(15) << FracBits;
	localparam logic [17:0] UTIL_RESET = 18'(1) << FracBits;

	// Sequencer states; the state is also the datapath operation.
	localparam logic [5:0] ST_IDLE = 6'd0;
	localparam logic [5:0] ST_P_BETA = 6'd1;
	localparam logic [5:0] ST_W_BETA = 6'd2;
	localparam logic [5:0] ST_P_UC = 6'd3;
	localparam logic [5:0] ST_P_BS = 6'd4;
	localparam logic [5:0] ST_SUM_VD = 6'd5;
	localparam logic [5:0] ST_W_VD = 6'd6;
	localparam logic [5:0] ST_P_BC = 6'd7;
	localparam logic [5:0] ST_P_US = 6'd8;
	localparam logic [5:0] ST_DIF_VQ = 6'd9;
	localparam logic [5:0] ST_W_VQ = 6'd10;
	localparam logic [5:0] ST_P_KK = 6'd11;
	localparam logic [5:0] ST_W_KK = 6'd12;
	localparam logic [5:0] ST_P_KI = 6'd13;
	localparam logic [5:0] ST_W_KI = 6'd14;
	localparam logic [5:0] ST_CAND = 6'd15;
	localparam logic [5:0] ST_P_KP = 6'd16;
	localparam logic [5:0] ST_W_KP = 6'd17;
	localparam logic [5:0] ST_PIOUT = 6'd18;
	localparam logic [5:0] ST_CMD = 6'd19;
	localparam logic [5:0] ST_P_R1 = 6'd20;
	localparam logic [5:0] ST_W_R1 = 6'd21;
	localparam logic [5:0] ST_P_R2 = 6'd22;
	localparam logic [5:0] ST_W_R2 = 6'd23;
	localparam logic [5:0] ST_P_D2 = 6'd24;
	localparam logic [5:0] ST_P_Q2 = 6'd25;
	localparam logic [5:0] ST_SUM_SQ = 6'd26;
	localparam logic [5:0] ST_P_RR = 6'd27;
	localparam logic [5:0] ST_CMP = 6'd28;
	localparam logic [5:0] ST_SQRT = 6'd29;
	localparam logic [5:0] ST_P_DR = 6'd30;
	localparam logic [5:0] ST_P_QR = 6'd31;
	localparam logic [5:0] ST_DINIT = 6'd32;
	localparam logic [5:0] ST_DIV = 6'd33;
	localparam logic [5:0] ST_FIN = 6'd34;
	localparam logic [5:0] ST_EMIT = 6'd35;

	typedef struct packed {
		logic signed [31:0] phase_u_volts;
		logic signed [31:0] line_vw_volts;
		logic signed [15:0] sine_angle;
		logic signed [15:0] cosine_angle;
		logic signed [31:0] d_reference;
		logic signed [31:0] dc_link_volts;
	} req_t;

	typedef struct packed {
		logic signed [31:0] meas_d;
		logic signed [31:0] meas_q;
		logic signed [31:0] drive_d;
		logic signed [31:0] drive_q;
		logic               was_limited;
		logic signed [31:0] d_integrator;
		logic signed [31:0] q_integrator;
	} rsp_t;

	typedef struct packed {
		logic        closed_loop_mode;
		logic [31:0] prop_gain;
		logic [31:0] integ_gain;
		logic [30:0] correction_limit;
		logic [17:0] utilization;
	} cfg_t;

	// Controller to datapath.
	typedef struct packed {
		logic [5:0] op;
		logic       axis;
		logic       load;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_scale;
		logic out_free;
		logic closed;
	} stat_t;

	// Saturate a widened sum to a signed 32-bit value.
	function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
		if (x > 34'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -34'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	// Shift a product right with rounding half away from zero, then saturate.
	function automatic logic signed [31:0] rnd_sat(input logic signed [67:0] x,
			input logic [4:0] s);
		logic        neg;
		logic [67:0] m;
		logic [67:0] h;
		logic [67:0] n;
		neg = x[67];
		m = neg ? 68'(-x) : 68'(x);
		h = (m + (68'd1 << (s - 5'd1))) >> s;
		n = 68'd0 - h;
		if (neg) begin
			if (h > 68'd2147483648) begin
				return 32'sh80000000;
			end
			return n[31:0];
		end
		if (h > 68'd2147483647) begin
			return 32'sh7fffffff;
		end
		return h[31:0];
	endfunction

endpackage

// File: rtl/core/dqvl_ctrl.sv
// ----------------------------------------------------------------------------
// dqvl_ctrl
// Sequencer of the dq regulator: steps the datapath through one transaction.
// ----------------------------------------------------------------------------
`include "dq_voltage_pi_with_vector_limit_top_defines.svh"

module dqvl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  dqvl_pkg::stat_t st,
	output dqvl_pkg::cmd_t  cmd
);

	logic [5:0] state_q;
	logic [5:0] state_d;
	logic       axis_q;
	logic       axis_d;
	logic [4:0] cnt_q;
	logic [4:0] cnt_d;

	assign req_ready = (state_q == dqvl_pkg::ST_IDLE);

	always_comb begin
		cmd.op = state_q;
		cmd.axis = axis_q;
		cmd.load = req_ready && req_valid;
	end

	// Next state: mostly a straight sequence with a few branches.
	always_comb begin
		state_d = state_q;
		axis_d = axis_q;
		cnt_d = cnt_q;
		unique case (state_q)
			dqvl_pkg::ST_IDLE: begin
				axis_d = 1'b0;
				cnt_d = '0;
				if (req_valid) begin
					state_d = dqvl_pkg::ST_P_BETA;
				end
			end
			dqvl_pkg::ST_P_BETA: state_d = dqvl_pkg::ST_W_BETA;
			dqvl_pkg::ST_W_BETA: state_d = dqvl_pkg::ST_P_UC;
			dqvl_pkg::ST_P_UC: state_d = dqvl_pkg::ST_P_BS;
			dqvl_pkg::ST_P_BS: state_d = dqvl_pkg::ST_SUM_VD;
			dqvl_pkg::ST_SUM_VD: state_d = dqvl_pkg::ST_W_VD;
			dqvl_pkg::ST_W_VD: state_d = dqvl_pkg::ST_P_BC;
			dqvl_pkg::ST_P_BC: state_d = dqvl_pkg::ST_P_US;
			dqvl_pkg::ST_P_US: state_d = dqvl_pkg::ST_DIF_VQ;
			dqvl_pkg::ST_DIF_VQ: state_d = dqvl_pkg::ST_W_VQ;
			dqvl_pkg::ST_W_VQ: begin
				state_d = st.closed ? dqvl_pkg::ST_P_KK : dqvl_pkg::ST_CMD;
			end
			dqvl_pkg::ST_P_KK: state_d = dqvl_pkg::ST_W_KK;
			dqvl_pkg::ST_W_KK: state_d = dqvl_pkg::ST_P_KI;
			dqvl_pkg::ST_P_KI: state_d = dqvl_pkg::ST_W_KI;
			dqvl_pkg::ST_W_KI: state_d = dqvl_pkg::ST_CAND;
			dqvl_pkg::ST_CAND: state_d = dqvl_pkg::ST_P_KP;
			dqvl_pkg::ST_P_KP: state_d = dqvl_pkg::ST_W_KP;
			dqvl_pkg::ST_W_KP: state_d = dqvl_pkg::ST_PIOUT;
			dqvl_pkg::ST_PIOUT: begin
				// The d regulator runs first, then the q regulator.
				if (axis_q) begin
					state_d = dqvl_pkg::ST_CMD;
				end else begin
					axis_d = 1'b1;
					state_d = dqvl_pkg::ST_P_KI;
				end
			end
			dqvl_pkg::ST_CMD: state_d = dqvl_pkg::ST_P_R1;
			dqvl_pkg::ST_P_R1: state_d = dqvl_pkg::ST_W_R1;
			dqvl_pkg::ST_W_R1: state_d = dqvl_pkg::ST_P_R2;
			dqvl_pkg::ST_P_R2: state_d = dqvl_pkg::ST_W_R2;
			dqvl_pkg::ST_W_R2: state_d = dqvl_pkg::ST_P_D2;
			dqvl_pkg::ST_P_D2: state_d = dqvl_pkg::ST_P_Q2;
			dqvl_pkg::ST_P_Q2: state_d = dqvl_pkg::ST_SUM_SQ;
			dqvl_pkg::ST_SUM_SQ: state_d = dqvl_pkg::ST_P_RR;
			dqvl_pkg::ST_P_RR: state_d = dqvl_pkg::ST_CMP;
			dqvl_pkg::ST_CMP: begin
				cnt_d = '0;
				state_d = st.need_scale ? dqvl_pkg::ST_SQRT : dqvl_pkg::ST_EMIT;
			end
			dqvl_pkg::ST_SQRT: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == dqvl_pkg::ITER_LAST) begin
					state_d = dqvl_pkg::ST_P_DR;
				end
			end
			dqvl_pkg::ST_P_DR: state_d = dqvl_pkg::ST_P_QR;
			dqvl_pkg::ST_P_QR: state_d = dqvl_pkg::ST_DINIT;
			dqvl_pkg::ST_DINIT: begin
				cnt_d = '0;
				state_d = dqvl_pkg::ST_DIV;
			end
			dqvl_pkg::ST_DIV: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == dqvl_pkg::ITER_LAST) begin
					state_d = dqvl_pkg::ST_FIN;
				end
			end
			dqvl_pkg::ST_FIN: state_d = dqvl_pkg::ST_EMIT;
			dqvl_pkg::ST_EMIT: begin
				if (st.out_free) begin
					state_d = dqvl_pkg::ST_IDLE;
				end
			end
			default: state_d = dqvl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqvl_pkg::ST_IDLE;
			axis_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			axis_q <= axis_d;
			cnt_q <= cnt_d;
		end
	end

	// An accepted transaction starts the Park transform next cycle.
	`DQVL_ASSERT_NEXT(a_start, cmd.load, state_q == dqvl_pkg::ST_P_BETA, "load did not start")
	// The square root hands over to the dividers after its last step.
	`DQVL_ASSERT_NEXT(a_sqrt_done, (state_q == dqvl_pkg::ST_SQRT) && (cnt_q == dqvl_pkg::ITER_LAST), state_q == dqvl_pkg::ST_P_DR, "sqrt overran")
	// A vector inside the circle goes straight to the result.
	`DQVL_ASSERT_NEXT(a_no_scale, (state_q == dqvl_pkg::ST_CMP) && !st.need_scale, state_q == dqvl_pkg::ST_EMIT, "unneeded scaling")

endmodule

// File: rtl/core/dqvl_dp.sv
// ----------------------------------------------------------------------------
// dqvl_dp
// Datapath of the dq regulator: shared multiplier, rounding, PI update,
// square root, two dividers and the result register.
// ----------------------------------------------------------------------------
module dqvl_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  dqvl_pkg::cfg_t  cfg,
	input  dqvl_pkg::req_t  req_data,
	input  dqvl_pkg::cmd_t  cmd,
	output dqvl_pkg::stat_t st,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output dqvl_pkg::rsp_t  rsp_data
);

	// Captured transaction.
	logic signed [31:0] uu_q, uvw_q, ref_q, vdc_q;
	logic signed [15:0] sn_q, cs_q;

	// Product and accumulator.
	logic signed [67:0] p_q, acc_q, prod;
	logic signed [33:0] ma, mb;

	// Intermediate values.
	logic signed [31:0] beta_q, vd_q, vq_q, kikp_q, errd_q, errq_q;
	logic signed [31:0] t_q, cand_q, pd_q, pq_q, ud_q, uq_q, r_q;
	logic signed [31:0] dint_q, qint_q;
	logic               lim_q;

	// Square root and dividers.
	logic [63:0] sv_q, res_q, bit_q, sq_try;
	logic [31:0] ms_q;
	logic [62:0] numd_q;
	logic [32:0] remd_q, remq_q, trd, trq;
	logic [31:0] lod_q, loq_q, quod_q, quoq_q;

	dqvl_pkg::rsp_t out_q;
	logic           out_valid_q;

	logic signed [31:0] err_sel, integ_sel, pi_o, pi_val;
	logic signed [33:0] ud_mag, uq_mag, lim34;
	logic               commit;

	// Status toward the sequencer.
	always_comb begin
		st.closed = cfg.closed_loop_mode;
		st.out_free = !out_valid_q || rsp_ready;
		st.need_scale = (r_q > 32'sd0) && (acc_q[63:0] > p_q[63:0]);
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data = out_q;

	assign err_sel = cmd.axis ? errq_q : errd_q;
	assign integ_sel = cmd.axis ? qint_q : dint_q;
	assign ud_mag = ud_q[31] ? -34'(ud_q) : 34'(ud_q);
	assign uq_mag = uq_q[31] ? -34'(uq_q) : 34'(uq_q);
	assign lim34 = 34'(cfg.correction_limit);

	// Operand selection of the shared multiplier.
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			dqvl_pkg::ST_P_BETA: begin ma = 34'(uvw_q); mb = dqvl_pkg::InvSqrt3Q30; end
			dqvl_pkg::ST_P_UC: begin ma = 34'(uu_q); mb = 34'(cs_q); end
			dqvl_pkg::ST_P_BS: begin ma = 34'(beta_q); mb = 34'(sn_q); end
			dqvl_pkg::ST_P_BC: begin ma = 34'(beta_q); mb = 34'(cs_q); end
			dqvl_pkg::ST_P_US: begin ma = 34'(uu_q); mb = 34'(sn_q); end
			dqvl_pkg::ST_P_KK: begin
				ma = {2'b00, cfg.integ_gain};
				mb = {2'b00, cfg.prop_gain};
			end
			dqvl_pkg::ST_P_KI: begin ma = 34'(kikp_q); mb = 34'(err_sel); end
			dqvl_pkg::ST_P_KP: begin ma = {2'b00, cfg.prop_gain}; mb = 34'(err_sel); end
			dqvl_pkg::ST_P_R1: begin ma = {16'd0, cfg.utilization}; mb = 34'(vdc_q); end
			dqvl_pkg::ST_P_R2: begin ma = 34'(r_q); mb = dqvl_pkg::InvSqrt3Q30; end
			dqvl_pkg::ST_P_D2: begin ma = 34'(ud_q); mb = 34'(ud_q); end
			dqvl_pkg::ST_P_Q2: begin ma = 34'(uq_q); mb = 34'(uq_q); end
			dqvl_pkg::ST_P_RR: begin ma = 34'(r_q); mb = 34'(r_q); end
			dqvl_pkg::ST_P_DR: begin ma = ud_mag; mb = 34'(r_q); end
			dqvl_pkg::ST_P_QR: begin ma = uq_mag; mb = 34'(r_q); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign prod = ma * mb;

	// PI output clamp and anti-windup decision.
	always_comb begin
		pi_o = dqvl_pkg::sat32(34'(t_q) + 34'(cand_q));
		if (34'(pi_o) > lim34) begin
			commit = err_sel[31];
			pi_val = 32'(lim34);
		end else if (34'(pi_o) < -lim34) begin
			commit = !err_sel[31] && (err_sel != 32'sd0);
			pi_val = 32'(-lim34);
		end else begin
			commit = 1'b1;
			pi_val = pi_o;
		end
	end

	// Square-root and divider trial values.
	assign sq_try = res_q + bit_q;
	assign trd = {remd_q[31:0], lod_q[31]};
	assign trq = {remq_q[31:0], loq_q[31]};

	// Payload registers, one operation per sequencer state.
	always_ff @(posedge clk) begin
		p_q <= prod;
		if (cmd.load) begin
			uu_q <= req_data.phase_u_volts;
			uvw_q <= req_data.line_vw_volts;
			sn_q <= req_data.sine_angle;
			cs_q <= req_data.cosine_angle;
			ref_q <= req_data.d_reference;
			vdc_q <= req_data.dc_link_volts;
		end
		case (cmd.op)
			dqvl_pkg::ST_W_BETA: beta_q <= dqvl_pkg::rnd_sat(p_q, dqvl_pkg::SHIFT_Q30);
			dqvl_pkg::ST_P_BS, dqvl_pkg::ST_P_US, dqvl_pkg::ST_P_Q2: acc_q <= p_q;
			dqvl_pkg::ST_SUM_VD, dqvl_pkg::ST_SUM_SQ: acc_q <= acc_q + p_q;
			dqvl_pkg::ST_DIF_VQ: acc_q <= acc_q - p_q;
			dqvl_pkg::ST_W_VD: vd_q <= dqvl_pkg::rnd_sat(acc_q, dqvl_pkg::SHIFT_PARK);
			dqvl_pkg::ST_W_VQ: vq_q <= dqvl_pkg::rnd_sat(acc_q, dqvl_pkg::SHIFT_PARK);
			dqvl_pkg::ST_P_KK: begin
				errd_q <= dqvl_pkg::sat32(34'(ref_q) - 34'(vd_q));
				errq_q <= dqvl_pkg::sat32(-34'(vq_q));
			end
			dqvl_pkg::ST_W_KK: kikp_q <= dqvl_pkg::rnd_sat(p_q, dqvl_pkg::SHIFT_FRAC);
			dqvl_pkg::ST_W_KI, dqvl_pkg::ST_W_KP: begin
				t_q <= dqvl_pkg::rnd_sat(p_q, dqvl_pkg::SHIFT_FRAC);
			end
			dqvl_pkg::ST_CAND: cand_q <= dqvl_pkg::sat32(34'(integ_sel) + 34'(t_q));
			dqvl_pkg::ST_PIOUT: begin
				if (cmd.axis) begin
					pq_q <= pi_val;
				end else begin
					pd_q <= pi_val;
				end
			end
			dqvl_pkg::ST_CMD: begin
				if (cfg.closed_loop_mode) begin
					ud_q <= dqvl_pkg::sat32(34'(ref_q) + 34'(pd_q));
					uq_q <= pq_q;
				end else begin
					ud_q <= ref_q;
					uq_q <= '0;
				end
			end
			dqvl_pkg::ST_W_R1: r_q <= dqvl_pkg::rnd_sat(p_q, dqvl_pkg::SHIFT_FRAC);
			dqvl_pkg::ST_W_R2: r_q <= dqvl_pkg::rnd_sat(p_q, dqvl_pkg::SHIFT_Q30);
			dqvl_pkg::ST_CMP: begin
				// Nonpositive radius zeroes the command; outside the circle scales it.
				if (r_q <= 32'sd0) begin
					ud_q <= '0;
					uq_q <= '0;
					lim_q <= 1'b1;
				end else begin
					lim_q <= acc_q[63:0] > p_q[63:0];
				end
				sv_q <= acc_q[63:0];
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			dqvl_pkg::ST_SQRT: begin
				if (sv_q >= sq_try) begin
					sv_q <= sv_q - sq_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			dqvl_pkg::ST_P_DR: ms_q <= (res_q == 64'd0) ? 32'd1 : res_q[31:0];
			dqvl_pkg::ST_P_QR: numd_q <= p_q[62:0];
			dqvl_pkg::ST_DINIT: begin
				remd_q <= {2'b00, numd_q[62:32]};
				lod_q <= numd_q[31:0];
				remq_q <= {2'b00, p_q[62:32]};
				loq_q <= p_q[31:0];
			end
			dqvl_pkg::ST_DIV: begin
				// One quotient bit per cycle for each component.
				if (trd >= {1'b0, ms_q}) begin
					remd_q <= trd - {1'b0, ms_q};
					quod_q <= {quod_q[30:0], 1'b1};
				end else begin
					remd_q <= trd;
					quod_q <= {quod_q[30:0], 1'b0};
				end
				if (trq >= {1'b0, ms_q}) begin
					remq_q <= trq - {1'b0, ms_q};
					quoq_q <= {quoq_q[30:0], 1'b1};
				end else begin
					remq_q <= trq;
					quoq_q <= {quoq_q[30:0], 1'b0};
				end
				lod_q <= {lod_q[30:0], 1'b0};
				loq_q <= {loq_q[30:0], 1'b0};
			end
			dqvl_pkg::ST_FIN: begin
				ud_q <= dqvl_pkg::sat32(ud_q[31] ? -34'(quod_q) : 34'(quod_q));
				uq_q <= dqvl_pkg::sat32(uq_q[31] ? -34'(quoq_q) : 34'(quoq_q));
			end
			dqvl_pkg::ST_EMIT: begin
				if (st.out_free) begin
					out_q.meas_d <= vd_q;
					out_q.meas_q <= vq_q;
					out_q.drive_d <= ud_q;
					out_q.drive_q <= uq_q;
					out_q.was_limited <= lim_q;
					out_q.d_integrator <= dint_q;
					out_q.q_integrator <= qint_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Regulator state and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dint_q <= '0;
			qint_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((cmd.op == dqvl_pkg::ST_PIOUT) && commit) begin
				if (cmd.axis) begin
					qint_q <= cand_q;
				end else begin
					dint_q <= cand_q;
				end
			end
			if ((cmd.op == dqvl_pkg::ST_EMIT) && st.out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/dq_voltage_pi_with_vector_limit_top.sv
// ----------------------------------------------------------------------------
// dq_voltage_pi_with_vector_limit_top
// dq-frame voltage regulator with two PI loops and a circular output limit.
// ----------------------------------------------------------------------------
// Usage: one transaction on the req channel carries the measured voltages,
// the grid angle, the d reference and the DC-link voltage; one transaction
// on the rsp channel returns the Park result, the limited command, the limit
// flag and both integrals. Gains, limit, utilization and the mode are set
// through the APB port; the user must write them only while the block is
// idle, which the block itself does not enforce. pready is always high.
// Closed loop runs both PI loops, open loop skips them; scaling a vector onto
// the circle adds a 32-step square root and two 32-step dividers side by side.
// One shared 34x34 multiplier sets the length of the main sequence.
// One transaction is worked on at a time; req_ready is high while idle, also
// while a finished result still waits in the output register.
// If the receiver stalls, the next result holds in its final step until the
// output register is free. Reset clears both integrals, the handshakes and
// loads the register defaults (closed loop, 15 V limit, utilization 1.0).
module dq_voltage_pi_with_vector_limit_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  dqvl_pkg::req_t                       req_data,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output dqvl_pkg::rsp_t                       rsp_data,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [dqvl_pkg::CfgAddrWidth-1:0]    paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	dqvl_pkg::cfg_t  cfg_q;
	dqvl_pkg::cmd_t  cmd;
	dqvl_pkg::stat_t st;
	logic            wr_en;
	logic [2:0]      reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.closed_loop_mode <= 1'b1;
			cfg_q.prop_gain <= '0;
			cfg_q.integ_gain <= '0;
			cfg_q.correction_limit <= dqvl_pkg::LIMIT_RESET;
			cfg_q.utilization <= dqvl_pkg::UTIL_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				dqvl_pkg::REG_MODE: cfg_q.closed_loop_mode <= pwdata[0];
				dqvl_pkg::REG_KP: cfg_q.prop_gain <= pwdata;
				dqvl_pkg::REG_KI: cfg_q.integ_gain <= pwdata;
				dqvl_pkg::REG_LIMIT: cfg_q.correction_limit <= pwdata[30:0];
				dqvl_pkg::REG_UTIL: cfg_q.utilization <= pwdata[17:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			dqvl_pkg::REG_MODE: prdata = {31'd0, cfg_q.closed_loop_mode};
			dqvl_pkg::REG_KP: prdata = cfg_q.prop_gain;
			dqvl_pkg::REG_KI: prdata = cfg_q.integ_gain;
			dqvl_pkg::REG_LIMIT: prdata = {1'b0, cfg_q.correction_limit};
			dqvl_pkg::REG_UTIL: prdata = {14'd0, cfg_q.utilization};
			default: prdata = '0;
		endcase
	end

	dqvl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	dqvl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_data  (req_data),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the dq voltage regulator with vector limit.
// A queue of pending transactions feeds a clocked driver; every accepted
// transaction is run through a fixed-point predictor of the Park transform,
// the two PI loops and the circular limit, and the expected result is queued.
// A clocked monitor compares each returned result field by field. The run
// steps through several register settings written over APB while idle.
// ----------------------------------------------------------------------------
module tb;

	localparam longint MaxPos = 64'sd2147483647;
	localparam longint MinNeg = -64'sd2147483648;
	localparam longint InvSqrt3 = 64'sd619925131;
	localparam int CycleLimit = 2000000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	dqvl_pkg::req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	dqvl_pkg::rsp_t rsp_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [dqvl_pkg::CfgAddrWidth-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// Shadow copy of the configuration and of the regulator state.
	bit mode_closed;
	logic [31:0] kp_gain;
	logic [31:0] ki_gain;
	logic [30:0] clamp_lim;
	logic [17:0] util_fac;
	longint d_integ;
	longint q_integ;

	dqvl_pkg::req_t pending_reqs[$];
	dqvl_pkg::rsp_t expected_rsps[$];
	int mismatches;
	int req_gap;
	int rsp_stall;
	bit no_idle;
	int cycles;

	dq_voltage_pi_with_vector_limit_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// Saturate to a signed 32-bit value.
	function automatic longint clip32(input longint x);
		if (x > MaxPos) return MaxPos;
		if (x < MinNeg) return MinNeg;
		return x;
	endfunction

	// Exact product, shifted right with rounding half away from zero, saturated.
	function automatic longint mul_round(input longint a, input longint b, input int s);
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		logic signed [127:0] p;
		logic [127:0] m;
		logic [127:0] h;
		wa = a;
		wb = b;
		p = wa * wb;
		m = (p < 0) ? -p : p;
		h = (m + (128'd1 << (s - 1))) >> s;
		if (p < 0) begin
			if (h > 128'd2147483648) return MinNeg;
			return -longint'(h[63:0]);
		end
		if (h > 128'd2147483647) return MaxPos;
		return longint'(h[63:0]);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v) probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] abs64(input longint x);
		return (x < 0) ? -x : x;
	endfunction

	// One PI regulator step with clamp and conditional integration.
	function automatic longint pi_step(inout longint integ, input longint err,
			input longint kikp);
		longint cand;
		longint outv;
		longint lim;
		lim = longint'(clamp_lim);
		cand = clip32(integ + mul_round(kikp, err, 16));
		outv = clip32(mul_round(longint'(kp_gain), err, 16) + cand);
		if (outv > lim) begin
			if (err < 0) integ = cand;
			return lim;
		end
		if (outv < -lim) begin
			if (err > 0) integ = cand;
			return -lim;
		end
		integ = cand;
		return outv;
	endfunction

	function automatic longint scale_axis(input longint c, input int k,
			input logic [63:0] rs, input logic [63:0] ms);
		logic [63:0] v;
		longint r;
		v = ((abs64(c) >> k) * rs) / ms;
		r = clip32(longint'(v << k));
		return (c < 0) ? clip32(-r) : r;
	endfunction

	// Circular limit of the command vector; returns the limit flag.
	function automatic bit circle_limit(inout longint d, inout longint q, input longint r);
		logic [127:0] mag_sq;
		logic [127:0] rad_sq;
		logic [63:0] m;
		logic [63:0] ds;
		logic [63:0] qs;
		logic [63:0] ms;
		int k;
		if (r <= 0) begin
			d = 0;
			q = 0;
			return 1;
		end
		mag_sq = 128'(abs64(d)) * abs64(d) + 128'(abs64(q)) * abs64(q);
		rad_sq = 128'(r) * 128'(r);
		if (mag_sq <= rad_sq) return 0;
		m = (abs64(d) > abs64(q)) ? abs64(d) : abs64(q);
		k = 0;
		while ((m >> k) > (64'd1 << 31)) k++;
		ds = abs64(d) >> k;
		qs = abs64(q) >> k;
		ms = int_sqrt(ds * ds + qs * qs);
		if (ms == 0) ms = 1;
		d = scale_axis(d, k, 64'(r) >> k, ms);
		q = scale_axis(q, k, 64'(r) >> k, ms);
		return 1;
	endfunction

	// Predict the result of one control tick and advance the integrals.
	function automatic dqvl_pkg::rsp_t regulate(input dqvl_pkg::req_t rq);
		dqvl_pkg::rsp_t res;
		longint uu;
		longint uvw;
		longint sn;
		longint cs;
		longint dref;
		longint beta;
		longint vd;
		longint vq;
		longint ud;
		longint uq;
		longint kikp;
		longint rad;
		bit lim;
		uu = rq.phase_u_volts;
		uvw = rq.line_vw_volts;
		sn = rq.sine_angle;
		cs = rq.cosine_angle;
		dref = rq.d_reference;
		beta = mul_round(uvw, InvSqrt3, 30);
		vd = mul_round(uu * cs + beta * sn, 1, 15);
		vq = mul_round(beta * cs - uu * sn, 1, 15);
		if (mode_closed) begin
			kikp = mul_round(longint'(ki_gain), longint'(kp_gain), 16);
			ud = clip32(dref + pi_step(d_integ, clip32(dref - vd), kikp));
			uq = pi_step(q_integ, clip32(-vq), kikp);
		end else begin
			ud = dref;
			uq = 0;
		end
		rad = mul_round(longint'(util_fac), longint'(rq.dc_link_volts), 16);
		rad = mul_round(rad, InvSqrt3, 30);
		lim = circle_limit(ud, uq, rad);
		res.meas_d = vd[31:0];
		res.meas_q = vq[31:0];
		res.drive_d = ud[31:0];
		res.drive_q = uq[31:0];
		res.was_limited = lim;
		res.d_integrator = d_integ[31:0];
		res.q_integrator = q_integ[31:0];
		return res;
	endfunction

	// Idle lengths: mostly none or short, now and then long.
	function automatic int pick_gap();
		int p;
		if (no_idle) return 0;
		p = $urandom_range(0, 19);
		if (p < 11) return 0;
		if (p < 18) return $urandom_range(1, 4);
		return $urandom_range(10, 45);
	endfunction

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			req_gap <= 0;
		end else if (!req_valid || req_ready) begin
			if (req_valid) begin
				expected_rsps.push_back(regulate(req_data));
			end
			if (req_gap > 0) begin
				req_gap <= req_gap - 1;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req_data <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				req_gap <= pick_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		dqvl_pkg::rsp_t exp_r;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_stall <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("Unexpected result %h", rsp_data);
				end else begin
					exp_r = expected_rsps.pop_front();
					if (exp_r.meas_d !== rsp_data.meas_d || exp_r.meas_q !== rsp_data.meas_q ||
							exp_r.drive_d !== rsp_data.drive_d ||
							exp_r.drive_q !== rsp_data.drive_q ||
							exp_r.was_limited !== rsp_data.was_limited ||
							exp_r.d_integrator !== rsp_data.d_integrator ||
							exp_r.q_integrator !== rsp_data.q_integrator) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch: vd %h/%h vq %h/%h ud %h/%h uq %h/%h",
								exp_r.meas_d, rsp_data.meas_d, exp_r.meas_q, rsp_data.meas_q,
								exp_r.drive_d, rsp_data.drive_d, exp_r.drive_q,
								rsp_data.drive_q);
							$display("  limited %b/%b integ_d %h/%h integ_q %h/%h",
								exp_r.was_limited, rsp_data.was_limited,
								exp_r.d_integrator, rsp_data.d_integrator,
								exp_r.q_integrator, rsp_data.q_integrator);
						end
					end
				end
			end
			if (rsp_stall > 0) begin
				rsp_stall <= rsp_stall - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				rsp_stall <= pick_gap();
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// APB register write; the shadow copy follows at the access edge.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			dqvl_pkg::REG_MODE: mode_closed = val[0];
			dqvl_pkg::REG_KP: kp_gain = val;
			dqvl_pkg::REG_KI: ki_gain = val;
			dqvl_pkg::REG_LIMIT: clamp_lim = val[30:0];
			dqvl_pkg::REG_UTIL: util_fac = val[17:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input bit m, input logic [31:0] kp, input logic [31:0] ki,
			input logic [30:0] lim, input logic [17:0] ut);
		write_reg(dqvl_pkg::REG_MODE,
			{$urandom_range(0, 1) ? $urandom() : 32'd0} & ~32'd1 | m);
		write_reg(dqvl_pkg::REG_KP, kp);
		write_reg(dqvl_pkg::REG_KI, ki);
		write_reg(dqvl_pkg::REG_LIMIT, {1'($urandom_range(0, 1)), lim});
		write_reg(dqvl_pkg::REG_UTIL, {14'($urandom()), ut});
	endtask

	// Wait until every queued transaction has been answered, then let the
	// block settle before the configuration changes.
	task automatic drain();
		do @(negedge clk);
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0);
		repeat (120) @(posedge clk);
	endtask

	task automatic add_req(input longint uu, input longint uvw, input int sn, input int cs,
			input longint dref, input longint vdc);
		dqvl_pkg::req_t r;
		r.phase_u_volts = uu[31:0];
		r.line_vw_volts = uvw[31:0];
		r.sine_angle = sn[15:0];
		r.cosine_angle = cs[15:0];
		r.d_reference = dref[31:0];
		r.dc_link_volts = vdc[31:0];
		pending_reqs.push_back(r);
	endtask

	// A voltage: mostly realistic, sometimes full range or an extreme.
	function automatic longint pick_volts(input longint span);
		int p;
		p = $urandom_range(0, 9);
		if (p < 7) return longint'($urandom_range(0, 2 * span)) - span;
		if (p < 9) return longint'(signed'($urandom()));
		case ($urandom_range(0, 4))
			0: return MaxPos;
			1: return MinNeg;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	task automatic add_random(input int count);
		real ang;
		int sn;
		int cs;
		longint vdc;
		repeat (count) begin
			ang = $urandom_range(0, 62831) / 10000.0;
			sn = $rtoi($sin(ang) * 32767.0);
			cs = $rtoi($cos(ang) * 32767.0);
			if ($urandom_range(0, 9) == 0) begin
				sn = signed'(16'($urandom()));
				cs = signed'(16'($urandom()));
			end
			vdc = longint'($urandom_range(0, 800)) << 16;
			if ($urandom_range(0, 9) < 2) vdc = pick_volts(64'sd1 << 26);
			add_req(pick_volts(64'sd1 << 25), pick_volts(64'sd1 << 26), sn, cs,
				pick_volts(64'sd1 << 25), vdc);
		end
	endtask

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hffffffff;
			2: return $urandom();
			default: return $urandom_range(0, 32'h40000);
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		cycles = 0;
		no_idle = 1'b0;
		mode_closed = 1'b1;
		kp_gain = 0;
		ki_gain = 0;
		clamp_lim = dqvl_pkg::LIMIT_RESET;
		util_fac = dqvl_pkg::UTIL_RESET;
		d_integ = 0;
		q_integ = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes and zero, inside and outside radius cases.
		add_req(MaxPos, MaxPos, 32767, 32767, MaxPos, MaxPos);
		add_req(MinNeg, MinNeg, -32768, -32768, MinNeg, MaxPos);
		add_req(MaxPos, MinNeg, -32768, 32767, 0, 0);
		add_req(MinNeg, MaxPos, 32767, -32768, 100 << 16, -(300 << 16));
		add_req(300 << 16, 0, 0, 32767, 50 << 16, 600 << 16);
		add_req(300 << 16, 200 << 16, 23170, 23170, 500 << 16, 400 << 16);
		add_req(0, 0, 0, 0, 0, MinNeg);
		add_req(-1, 1, -1, 1, -1, 1);
		add_req(0, 0, 0, 0, MaxPos, 1 << 16);
		add_req(0, 0, 0, 0, MinNeg, MaxPos);
		drain();

		// Closed loop with moderate gains, then saturating gains.
		write_all(1'b1, 32'h10000, 32'h2000, 15 << 16, 18'h10000);
		add_req(MaxPos, MinNeg, 32767, -32768, MinNeg, MaxPos);
		add_random(100);
		drain();
		write_all(1'b1, 32'hffffffff, 32'hffffffff, 31'h7fffffff, 18'd131072);
		add_random(100);
		drain();
		// Open loop with zero radius.
		write_all(1'b0, 32'h8000, 32'h100, 15 << 16, 18'd0);
		add_random(100);
		drain();
		// Zero gains and zero clamp.
		write_all(1'b1, 32'd0, 32'd0, 31'd0, 18'd131072);
		add_random(100);
		drain();
		no_idle = 1'b1;
		write_all(1'b0, 32'h10000, 32'h10000, 15 << 16, 18'h8000);
		add_random(100);
		drain();
		no_idle = 1'b0;

		// Random settings.
		repeat (5) begin
			write_all(1'($urandom_range(0, 3) != 0), pick_gain(), pick_gain(),
				($urandom_range(0, 3) == 0) ? 31'($urandom()) :
					31'($urandom_range(0, 100 << 16)),
				18'($urandom_range(0, 131072)));
			no_idle = ($urandom_range(0, 4) == 0);
			add_random(110);
			drain();
		end

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dqvl_pkg.sv
rtl/core/dqvl_ctrl.sv
rtl/core/dqvl_dp.sv
rtl/core/dq_voltage_pi_with_vector_limit_top.sv
tb/tb.sv
